[hw/rtl/sgjg_pkg.sv]
// Shared constants, register indexes and controller/datapath interface types.
package sgjg_pkg;

  localparam int JOINT_COUNT      = 14;
  localparam int SINE_ENTRIES_DEF = 1024;
  localparam int STEP_PERIOD      = 112;

  // Phase angles run in 0.05 degree units over one full turn.
  localparam int TURN      = 7200;
  localparam int HALF_TURN = 3600;

  // Reciprocal of one turn, scaled by 2^RECIP_SHIFT and rounded up.
  localparam int             RECIP_SHIFT = 38;
  localparam int             RECIP_W     = 26;
  localparam longint unsigned RECIP      = 64'd38177488;

  // Magnitude above 0.2 degree, in 0.1 degree times 2^15.
  localparam int SHOW_LIMIT = 65536;

  // Field widths.
  localparam int MODE_W   = 2;
  localparam int AMP_W    = 10;
  localparam int PHASE_W  = 12;
  localparam int DIV_W    = 8;
  localparam int STEP_W   = 7;
  localparam int JOINT_W  = 4;
  localparam int MULT_W   = 5;
  localparam int OFF_W    = 17;
  localparam int QOFF_W   = 4;
  localparam int ANGLE_W  = 13;
  localparam int BASEK_W  = 13;
  localparam int SINE_W   = 16;
  localparam int PROD_W   = 27;
  localparam int OUT_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Base angle steps in 0.05 degree units: 45 and 22.5 degrees.
  localparam int BASE_EVEN = 900;
  localparam int BASE_ODD  = 450;

  // Gait modes.
  localparam logic [MODE_W-1:0] GAIT_NONE     = 2'd0;
  localparam logic [MODE_W-1:0] GAIT_SINUOUS  = 2'd1;
  localparam logic [MODE_W-1:0] GAIT_SIDEWIND = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GAIT_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DORSAL_AMP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DORSAL_PH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_AMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LATERAL_PH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_DIV    = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [MODE_W-1:0]  RST_GAIT_MODE   = GAIT_SIDEWIND;
  localparam logic [AMP_W-1:0]   RST_DORSAL_AMP  = 10'd480;
  localparam logic [PHASE_W-1:0] RST_DORSAL_PH   = 12'd2330;
  localparam logic [AMP_W-1:0]   RST_LATERAL_AMP = 10'd486;
  localparam logic [PHASE_W-1:0] RST_LATERAL_PH  = 12'd393;
  localparam logic [DIV_W-1:0]   RST_TICK_DIV    = 8'd2;

  typedef struct packed {
    logic tick_acc;   // tick beat taken: advance counters
    logic capture;    // gait step: latch joint, amplitude and offset
    logic load_quo;
    logic load_red;
    logic load_idx;
    logic load_rom;
    logic load_prod;
    logic load_out;
  } sgjg_cmd_t;

  typedef struct packed {
    logic fire;       // this tick is a gait step with an active gait
    logic show;       // product magnitude clears the display threshold
  } sgjg_sts_t;

endpackage

[hw/rtl/snake_gait_joint_generator_top.sv]
// A step tick's beat moves through the quotient, reduction, index, ROM, product and done states;
// later ticks stall until it is loaded or dropped, as the two reciprocal multiplies that
// reduce the phase, the registered sine ROM read and the amplitude multiply run in sequence.
// Ticks that are not gait steps, or come with gait mode off, are taken every cycle when idle.
// Reset: synchronous active-low rst_n restores the register defaults and clears the
// divider and step counters; there is no clearing pass.
module snake_gait_joint_generator_top #(
  parameter int SINE_ENTRIES = sgjg_pkg::SINE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // tick channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_tick,
  // joint goal channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [sgjg_pkg::JOINT_W-1:0]       out_joint_slot,
  output logic signed [sgjg_pkg::OUT_W-1:0]  out_joint_angle,
  // configuration writes
  input  logic                               cfg_wr_en,
  input  logic [sgjg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgjg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // The controller walks each gait step through the datapath stages:
  // capture joint and offset, reduce the offset modulo a turn, form the
  // rounded table index, read the sine ROM, scale by amplitude, and finally
  // threshold and hand the beat to the output register. The output register
  // frees the pipeline as soon as it is loaded, so a waiting beat on the
  // output side does not hold back the next tick, though that tick's beat waits in the done state.
  sgjg_pkg::sgjg_cmd_t cmd;
  sgjg_pkg::sgjg_sts_t sts;

  sgjg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_tick   (in_tick),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sgjg_dp #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .sts             (sts),
    .out_joint_slot  (out_joint_slot),
    .out_joint_angle (out_joint_angle)
  );

endmodule

[hw/rtl/sgjg_ctrl.sv]
// Sequencing state machine for the gait joint generator.
module sgjg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_tick,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  sgjg_pkg::sgjg_sts_t sts,
  output sgjg_pkg::sgjg_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_QUO  = 3'd1;
  localparam logic [2:0] ST_RED  = 3'd2;
  localparam logic [2:0] ST_IDX  = 3'd3;
  localparam logic [2:0] ST_ROM  = 3'd4;
  localparam logic [2:0] ST_PROD = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_take;
  logic       out_free;

  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    cmd.tick_acc  = in_take && in_tick;
    cmd.capture   = in_take && in_tick && sts.fire;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.capture) begin
          state_nxt = ST_QUO;
        end
      end
      ST_QUO: begin
        cmd.load_quo = 1'b1;
        state_nxt    = ST_RED;
      end
      ST_RED: begin
        cmd.load_red = 1'b1;
        state_nxt    = ST_IDX;
      end
      ST_IDX: begin
        cmd.load_idx = 1'b1;
        state_nxt    = ST_ROM;
      end
      ST_ROM: begin
        cmd.load_rom = 1'b1;
        state_nxt    = ST_PROD;
      end
      ST_PROD: begin
        cmd.load_prod = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        // drop small angles; otherwise wait for a free output slot
        if (!sts.show) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/sgjg_dp.sv]
// Datapath: configuration, step counters, phase reduction, sine ROM and output register.
module sgjg_dp #(
  parameter int SINE_ENTRIES = sgjg_pkg::SINE_ENTRIES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [sgjg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sgjg_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  sgjg_pkg::sgjg_cmd_t                  cmd,
  output sgjg_pkg::sgjg_sts_t                  sts,
  output logic [sgjg_pkg::JOINT_W-1:0]         out_joint_slot,
  output logic signed [sgjg_pkg::OUT_W-1:0]    out_joint_angle
);

  localparam int IDX_W = $clog2(SINE_ENTRIES);
  localparam int SI_W  = $clog2(SINE_ENTRIES + 1);
  localparam int X_W   = $clog2(sgjg_pkg::TURN * SINE_ENTRIES + sgjg_pkg::HALF_TURN + 1);
  localparam int XP_W  = X_W + sgjg_pkg::RECIP_W;
  localparam int OP_W  = sgjg_pkg::OFF_W + sgjg_pkg::RECIP_W;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic signed [sgjg_pkg::SINE_W-1:0] sine_rom_t [SINE_ENTRIES];

  // Taylor term divisor (2t)(2t+1).
  function automatic longint unsigned term_div(input longint unsigned v, input int t);
    longint unsigned q;
    unique case (t)
      1:       q = v / 6;
      2:       q = v / 20;
      3:       q = v / 42;
      4:       q = v / 72;
      5:       q = v / 110;
      6:       q = v / 156;
      default: q = v / 210;
    endcase
    return q;
  endfunction

  // Full-turn Q1.15 sine table built from a quarter-wave Q30 series.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned a;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned mag;
    longint unsigned r;
    longint          sum;
    logic            neg;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      a   = longint'(i) * 4;
      neg = 1'b0;
      if (a >= 2 * SINE_ENTRIES) begin
        a   = a - 2 * SINE_ENTRIES;
        neg = 1'b1;
      end
      if (a > SINE_ENTRIES) begin
        a = 2 * SINE_ENTRIES - a;
      end
      x   = (a * HALF_PI_Q30) / SINE_ENTRIES;
      x2  = (x * x) >> 30;
      mag = x;
      sum = longint'(x);
      for (int t = 1; t <= 7; t++) begin
        mag = term_div((mag * x2) >> 30, t);
        if (t % 2 == 1) begin
          sum = sum - longint'(mag);
        end else begin
          sum = sum + longint'(mag);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      r = (longint'(sum) * 32768 + (64'd1 << 29)) >> 30;
      if (r > 32767) begin
        r = 32767;
      end
      rom[i] = neg ? -(sgjg_pkg::SINE_W'(r)) : sgjg_pkg::SINE_W'(r);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Configuration registers.
  logic [sgjg_pkg::MODE_W-1:0]  gait_mode_r;
  logic [sgjg_pkg::AMP_W-1:0]   dorsal_amp_r, lateral_amp_r;
  logic [sgjg_pkg::PHASE_W-1:0] dorsal_ph_r, lateral_ph_r;
  logic [sgjg_pkg::DIV_W-1:0]   tick_div_r;

  // Step state.
  logic [sgjg_pkg::DIV_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic [sgjg_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [sgjg_pkg::JOINT_W-1:0] col_r, col_nxt;

  // Work registers.
  logic [sgjg_pkg::JOINT_W-1:0] slot_r;
  logic [sgjg_pkg::AMP_W-1:0]   amp_r;
  logic [sgjg_pkg::OFF_W-1:0]   off_r;
  logic [sgjg_pkg::BASEK_W-1:0] basek_r;
  logic [sgjg_pkg::QOFF_W-1:0]  qoff_r;
  logic [X_W-1:0]               x_r;
  logic [IDX_W-1:0]             si_r;
  logic signed [sgjg_pkg::SINE_W-1:0] sine_r;
  logic signed [sgjg_pkg::PROD_W-1:0] prod_r;

  // Capture-stage logic.
  logic                         sinuous;
  logic [sgjg_pkg::JOINT_W-1:0] joint;
  logic [sgjg_pkg::MULT_W-1:0]  mult;
  logic [sgjg_pkg::PHASE_W-1:0] phase;
  logic [sgjg_pkg::AMP_W-1:0]   amp;
  logic [sgjg_pkg::BASEK_W-1:0] basek;
  logic [sgjg_pkg::OFF_W-1:0]   off;
  logic [sgjg_pkg::DIV_W:0]     div_inc;
  logic [sgjg_pkg::DIV_W-1:0]   div_eff;

  // Reduction logic.
  logic [OP_W-1:0]              off_prod;
  logic [sgjg_pkg::OFF_W-1:0]   off_rem;
  logic [sgjg_pkg::ANGLE_W:0]   ang_sum;
  logic [sgjg_pkg::ANGLE_W-1:0] ang;
  logic [XP_W-1:0]              x_prod;
  logic [SI_W-1:0]              si_full;

  // Output logic.
  logic [sgjg_pkg::PROD_W-1:0]  pmag;
  logic [sgjg_pkg::PROD_W-1:0]  pround;
  logic [sgjg_pkg::OUT_W-1:0]   mag;

  // Status to the controller.
  logic                         fire;
  logic                         show;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gait_mode_r   <= sgjg_pkg::RST_GAIT_MODE;
      dorsal_amp_r  <= sgjg_pkg::RST_DORSAL_AMP;
      dorsal_ph_r   <= sgjg_pkg::RST_DORSAL_PH;
      lateral_amp_r <= sgjg_pkg::RST_LATERAL_AMP;
      lateral_ph_r  <= sgjg_pkg::RST_LATERAL_PH;
      tick_div_r    <= sgjg_pkg::RST_TICK_DIV;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sgjg_pkg::CFG_GAIT_MODE:   gait_mode_r   <= cfg_wdata[sgjg_pkg::MODE_W-1:0];
        sgjg_pkg::CFG_DORSAL_AMP:  dorsal_amp_r  <= cfg_wdata[sgjg_pkg::AMP_W-1:0];
        sgjg_pkg::CFG_DORSAL_PH:   dorsal_ph_r   <= cfg_wdata[sgjg_pkg::PHASE_W-1:0];
        sgjg_pkg::CFG_LATERAL_AMP: lateral_amp_r <= cfg_wdata[sgjg_pkg::AMP_W-1:0];
        sgjg_pkg::CFG_LATERAL_PH:  lateral_ph_r  <= cfg_wdata[sgjg_pkg::PHASE_W-1:0];
        sgjg_pkg::CFG_TICK_DIV:    tick_div_r    <= cfg_wdata[sgjg_pkg::DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // Divider and step counters; the joint column tracks step mod 14.
  always_comb begin
    div_eff     = (tick_div_r == '0) ? sgjg_pkg::DIV_W'(1) : tick_div_r;
    div_inc     = {1'b0, div_cnt_r} + (sgjg_pkg::DIV_W + 1)'(1);
    div_cnt_nxt = (div_inc >= {1'b0, div_eff}) ? '0 : div_inc[sgjg_pkg::DIV_W-1:0];
    step_nxt    = step_r;
    col_nxt     = col_r;
    if (div_cnt_r == '0) begin
      step_nxt = (step_r == sgjg_pkg::STEP_W'(sgjg_pkg::STEP_PERIOD - 1)) ?
                 '0 : step_r + sgjg_pkg::STEP_W'(1);
      col_nxt  = (col_r == sgjg_pkg::JOINT_W'(sgjg_pkg::JOINT_COUNT - 1)) ?
                 '0 : col_r + sgjg_pkg::JOINT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
      step_r    <= '0;
      col_r     <= '0;
    end else if (cmd.tick_acc) begin
      div_cnt_r <= div_cnt_nxt;
      step_r    <= step_nxt;
      col_r     <= col_nxt;
    end
  end

  assign fire = (div_cnt_r == '0) &&
                (gait_mode_r == sgjg_pkg::GAIT_SINUOUS ||
                 gait_mode_r == sgjg_pkg::GAIT_SIDEWIND);

  assign sts = '{fire: fire, show: show};

  // Joint selection and phase offset multiplier.
  always_comb begin
    sinuous = (gait_mode_r == sgjg_pkg::GAIT_SINUOUS);
    joint   = sinuous ? col_r : (col_r ^ sgjg_pkg::JOINT_W'(1));
    if (!joint[0]) begin
      amp   = dorsal_amp_r;
      phase = dorsal_ph_r;
      mult  = sinuous ? {joint, 1'b0} : sgjg_pkg::MULT_W'(joint) + sgjg_pkg::MULT_W'(1);
      basek = sgjg_pkg::BASEK_W'(step_r[2:0]) * sgjg_pkg::BASEK_W'(sgjg_pkg::BASE_EVEN);
    end else begin
      amp   = lateral_amp_r;
      phase = lateral_ph_r;
      mult  = sinuous ? sgjg_pkg::MULT_W'(joint) + sgjg_pkg::MULT_W'(2) :
                        {joint - sgjg_pkg::JOINT_W'(1), 1'b0};
      basek = sgjg_pkg::BASEK_W'(step_r[3:0]) * sgjg_pkg::BASEK_W'(sgjg_pkg::BASE_ODD);
    end
    off = sgjg_pkg::OFF_W'(mult) * sgjg_pkg::OFF_W'(phase);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot_r  <= sgjg_pkg::JOINT_W'(sgjg_pkg::JOINT_COUNT - 1) - joint;
      amp_r   <= amp;
      off_r   <= off;
      basek_r <= basek;
    end
  end

  // Offset reduced modulo one turn by reciprocal multiply.
  assign off_prod = OP_W'(off_r) * OP_W'(sgjg_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (cmd.load_quo) begin
      qoff_r <= off_prod[sgjg_pkg::RECIP_SHIFT +: sgjg_pkg::QOFF_W];
    end
  end

  always_comb begin
    off_rem = off_r - sgjg_pkg::OFF_W'(qoff_r) * sgjg_pkg::OFF_W'(sgjg_pkg::TURN);
    ang_sum = (sgjg_pkg::ANGLE_W + 1)'(basek_r) + (sgjg_pkg::ANGLE_W + 1)'(off_rem);
    ang     = (ang_sum >= (sgjg_pkg::ANGLE_W + 1)'(sgjg_pkg::TURN)) ?
              sgjg_pkg::ANGLE_W'(ang_sum - (sgjg_pkg::ANGLE_W + 1)'(sgjg_pkg::TURN)) :
              ang_sum[sgjg_pkg::ANGLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_red) begin
      x_r <= X_W'(ang) * X_W'(SINE_ENTRIES) + X_W'(sgjg_pkg::HALF_TURN);
    end
  end

  // Rounded table index, wrapped at the top.
  assign x_prod  = XP_W'(x_r) * XP_W'(sgjg_pkg::RECIP);
  assign si_full = x_prod[sgjg_pkg::RECIP_SHIFT +: SI_W];

  always_ff @(posedge clk) begin
    if (cmd.load_idx) begin
      si_r <= (si_full >= SI_W'(SINE_ENTRIES)) ?
              IDX_W'(si_full - SI_W'(SINE_ENTRIES)) : si_full[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_rom) begin
      sine_r <= SINE_ROM[si_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_prod) begin
      prod_r <= $signed({1'b0, amp_r}) * sine_r;
    end
  end

  // Threshold, round halves away from zero, restore sign.
  always_comb begin
    pmag   = prod_r[sgjg_pkg::PROD_W-1] ? sgjg_pkg::PROD_W'(-prod_r) :
                                          sgjg_pkg::PROD_W'(prod_r);
    pround = pmag + sgjg_pkg::PROD_W'(16384);
    mag    = pround[15 +: sgjg_pkg::OUT_W];
    show   = (pmag > sgjg_pkg::PROD_W'(sgjg_pkg::SHOW_LIMIT));
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_joint_slot  <= slot_r;
      out_joint_angle <= prod_r[sgjg_pkg::PROD_W-1] ? $signed(-mag) : $signed(mag);
    end
  end

endmodule

[tb/sv/snake_gait_joint_generator_top_tb.sv]
// Self-checking testbench for the serpenoid gait joint generator: random ticks and settings.
module snake_gait_joint_generator_top_tb;
  import sgjg_pkg::*;

  localparam int SINE_N       = SINE_ENTRIES_DEF;
  localparam int RANDOM_TICKS = 1500;
  localparam int PRESS_TICKS  = 150;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int MAX_SHOWN    = 10;

  // Mode 3 has no name in the package; it behaves like no gait.
  localparam logic [MODE_W-1:0] GAIT_UNDEFINED = 2'd3;

  typedef struct packed {
    logic [JOINT_W-1:0]       slot;
    logic signed [OUT_W-1:0]  angle;
  } joint_goal_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_tick = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [JOINT_W-1:0]         out_joint_slot;
  logic signed [OUT_W-1:0]    out_joint_angle;
  logic                       cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

  snake_gait_joint_generator_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_tick         (in_tick),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_joint_slot  (out_joint_slot),
    .out_joint_angle (out_joint_angle),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor copy of the registers and the two counters.
  logic [MODE_W-1:0]  gait_sel;
  logic [AMP_W-1:0]   d_amp, l_amp;
  logic [PHASE_W-1:0] d_ph, l_ph;
  logic [DIV_W-1:0]   div_set, div_cnt;
  logic [STEP_W-1:0]  step_k;
  int                 sine_q15 [SINE_N];

  bit                 ticks_pending[$];
  joint_goal_t        joint_goals_due[$];

  // Driver and receiver pacing state; each is written by one process only.
  bit  beat_open = 1'b0;
  int  tx_gap = 0, tx_burst = 0;
  int  rx_gap = 0, rx_burst = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  hold_req = 1'b0;
  int  mismatches = 0;
  int  cycle_count = 0;

  // Most gaps are zero or short, a few are long, and now and then a burst of
  // back-to-back cycles with no gap at all.
  function automatic int draw_gap(inout int burst);
    int roll;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    roll = $urandom_range(99);
    if (roll < 5) begin
      burst = $urandom_range(60, 20);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("%s", msg);
  endtask

  // Work out the joint goal for one accepted tick beat and advance the counters.
  task automatic serpenoid_step(input logic tk);
    int unsigned divn, k, j, amp, off, base, ang, si, pmag, mag, nxt;
    int          prod, sa;
    joint_goal_t g;
    if (!tk) return;
    divn = (div_set == 0) ? 1 : div_set;
    if (div_cnt == 0 && (gait_sel == GAIT_SINUOUS || gait_sel == GAIT_SIDEWIND)) begin
      k = step_k;
      j = k % JOINT_COUNT;
      // Sidewinding swaps each joint with its pair partner.
      if (gait_sel == GAIT_SIDEWIND) j = j ^ 1;
      if (j % 2 == 0) begin
        amp  = d_amp;
        base = BASE_EVEN;
        off  = (gait_sel == GAIT_SINUOUS) ? 2 * j * d_ph : (j + 1) * d_ph;
      end else begin
        amp  = l_amp;
        base = BASE_ODD;
        off  = (gait_sel == GAIT_SINUOUS) ? (j + 2) * l_ph : 2 * (j - 1) * l_ph;
      end
      ang = (base * k + off) % TURN;
      si  = (ang * SINE_N + TURN / 2) / TURN;
      if (si >= SINE_N) si -= SINE_N;
      prod = int'(amp) * sine_q15[si];
      pmag = (prod < 0) ? -prod : prod;
      // Drop angles of 0.2 degree or less.
      if (pmag > SHOW_LIMIT) begin
        mag = (pmag + 16384) >> 15;
        sa  = (prod < 0) ? -int'(mag) : int'(mag);
        g.slot  = JOINT_W'(JOINT_COUNT - 1 - j);
        g.angle = sa[OUT_W-1:0];
        joint_goals_due.push_back(g);
      end
    end
    if (div_cnt == 0) step_k = STEP_W'((step_k + 1) % STEP_PERIOD);
    nxt = int'(div_cnt) + 1;
    div_cnt = (nxt >= divn) ? '0 : nxt[DIV_W-1:0];
  endtask

  // Tick driver: take the next beat from the pending queue after a random gap,
  // hold the beat steady while the block stalls it, and predict on acceptance.
  always @(posedge clk) begin : drive_ticks
    if (!rst_n) begin
      in_valid <= 1'b0;
      beat_open = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        serpenoid_step(in_tick);
        beat_open = 1'b0;
      end
      if (!beat_open) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (ticks_pending.size() != 0) begin
          in_tick  <= ticks_pending.pop_front();
          in_valid <= 1'b1;
          beat_open = 1'b1;
          tx_gap = draw_gap(tx_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver pacing. Once the stimulus asks for it, hold off for a long
  // stretch so the block backs up and stalls the tick channel.
  always @(posedge clk) begin : pace_receiver
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      rx_gap = draw_gap(rx_burst);
    end
  end

  // Joint goal monitor: compare each accepted beat with the oldest prediction.
  always @(posedge clk) begin : watch_goals
    joint_goal_t g;
    if (rst_n && out_valid && !out_stall) begin
      if (joint_goals_due.size() == 0) begin
        report_mismatch($sformatf("unexpected joint beat: slot %0d angle %0d",
                                  out_joint_slot, out_joint_angle));
      end else begin
        g = joint_goals_due.pop_front();
        if (out_joint_slot !== g.slot || out_joint_angle !== g.angle)
          report_mismatch($sformatf("joint beat mismatch: slot exp %0d got %0d, angle exp %0d got %0d",
                                    g.slot, out_joint_slot, g.angle, out_joint_angle));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Write one register and mirror it into the predictor copy.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_GAIT_MODE:   gait_sel = val[MODE_W-1:0];
      CFG_DORSAL_AMP:  d_amp    = val[AMP_W-1:0];
      CFG_DORSAL_PH:   d_ph     = val[PHASE_W-1:0];
      CFG_LATERAL_AMP: l_amp    = val[AMP_W-1:0];
      CFG_LATERAL_PH:  l_ph     = val[PHASE_W-1:0];
      CFG_TICK_DIV:    div_set  = val[DIV_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_ticks(input int n);
    repeat (n) ticks_pending.push_back(1'b1);
  endtask

  // Wait for the tick queue and every predicted beat to drain, then give the
  // block time to finish ticks that carry no result.
  task automatic wait_idle();
    while (ticks_pending.size() != 0 || beat_open || joint_goals_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_amp();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return 900;
    if (roll < 30) return 1023;
    if (roll < 45) return CFG_DATA_W'($urandom_range(6, 1));
    return CFG_DATA_W'($urandom_range(1023));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_phase();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return 3599;
    if (roll < 30) return 4095;
    return CFG_DATA_W'($urandom_range(4095));
  endfunction

  initial begin : stimulus
    longint unsigned a, x, x2, term, r;
    longint          acc;
    bit              neg;
    int              roll, n, sent_ticks;
    logic [CFG_DATA_W-1:0] mode_val, div_val;

    // Build the Q1.15 sine table over a full turn from a quarter-wave series.
    for (int i = 0; i < SINE_N; i++) begin
      a   = i * 4;
      neg = 1'b0;
      if (a >= 2 * SINE_N) begin
        a  -= 2 * SINE_N;
        neg = 1'b1;
      end
      if (a > SINE_N) a = 2 * SINE_N - a;
      x    = (a * 64'd1686629713) / SINE_N;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int t = 1; t <= 7; t++) begin
        term = ((term * x2) >> 30) / longint'((2 * t) * (2 * t + 1));
        if (t % 2 == 1) acc -= longint'(term);
        else            acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      r = (longint'(acc) * 32768 + (64'd1 << 29)) >> 30;
      if (r > 32767) r = 32767;
      sine_q15[i] = neg ? -int'(r) : int'(r);
    end

    gait_sel = RST_GAIT_MODE;
    d_amp    = RST_DORSAL_AMP;
    d_ph     = RST_DORSAL_PH;
    l_amp    = RST_LATERAL_AMP;
    l_ph     = RST_LATERAL_PH;
    div_set  = RST_TICK_DIV;
    div_cnt  = '0;
    step_k   = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, with idle ticks mixed in.
    ticks_pending = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
    wait_idle();

    // Sinuous gait, zero divider acting as one, amplitude and phase registers at their top codes.
    put_reg(CFG_GAIT_MODE, GAIT_SINUOUS);
    put_reg(CFG_DORSAL_AMP, 1023);
    put_reg(CFG_DORSAL_PH, 4095);
    put_reg(CFG_LATERAL_AMP, 1023);
    put_reg(CFG_LATERAL_PH, 4095);
    put_reg(CFG_TICK_DIV, 0);
    end_writes();
    push_ticks(5);
    wait_idle();

    // Sidewinding at the nominal limits with a slow divider; leave the count midway.
    put_reg(CFG_GAIT_MODE, GAIT_SIDEWIND);
    put_reg(CFG_DORSAL_AMP, 900);
    put_reg(CFG_DORSAL_PH, 3599);
    put_reg(CFG_LATERAL_AMP, 900);
    put_reg(CFG_LATERAL_PH, 3599);
    put_reg(CFG_TICK_DIV, 8);
    end_writes();
    push_ticks(5);
    wait_idle();

    // Lower the divider below the running count, with no gait selected.
    put_reg(CFG_TICK_DIV, 3);
    put_reg(CFG_GAIT_MODE, GAIT_NONE);
    end_writes();
    push_ticks(3);
    wait_idle();

    put_reg(CFG_GAIT_MODE, GAIT_UNDEFINED);
    end_writes();
    push_ticks(2);
    wait_idle();

    // Zero amplitudes and phases: every angle falls under the threshold.
    put_reg(CFG_GAIT_MODE, GAIT_SIDEWIND);
    put_reg(CFG_DORSAL_AMP, 0);
    put_reg(CFG_LATERAL_AMP, 0);
    put_reg(CFG_DORSAL_PH, 0);
    put_reg(CFG_LATERAL_PH, 0);
    end_writes();
    push_ticks(2);
    wait_idle();

    // Back-pressure: a joint beat on nearly every tick while the receiver holds off.
    put_reg(CFG_GAIT_MODE, GAIT_SINUOUS);
    put_reg(CFG_TICK_DIV, 1);
    put_reg(CFG_DORSAL_AMP, 900);
    put_reg(CFG_LATERAL_AMP, 900);
    put_reg(CFG_DORSAL_PH, 1000);
    put_reg(CFG_LATERAL_PH, 700);
    end_writes();
    hold_req <= 1'b1;
    push_ticks(PRESS_TICKS);
    wait_idle();

    // Random settings, each followed by a run of mostly live ticks.
    sent_ticks = 0;
    while (sent_ticks < RANDOM_TICKS) begin
      roll = $urandom_range(99);
      mode_val = CFG_DATA_W'((roll < 45) ? GAIT_SINUOUS : (roll < 90) ? GAIT_SIDEWIND :
                             (roll < 95) ? GAIT_NONE : GAIT_UNDEFINED);
      roll = $urandom_range(99);
      div_val = (roll < 10) ? '0 : (roll < 15) ? CFG_DATA_W'(255) :
                (roll < 25) ? CFG_DATA_W'($urandom_range(255, 5)) :
                              CFG_DATA_W'($urandom_range(4, 1));
      if ($urandom_range(9) < 7) put_reg(CFG_GAIT_MODE, mode_val);
      if ($urandom_range(9) < 7) put_reg(CFG_DORSAL_AMP, pick_amp());
      if ($urandom_range(9) < 7) put_reg(CFG_DORSAL_PH, pick_phase());
      if ($urandom_range(9) < 7) put_reg(CFG_LATERAL_AMP, pick_amp());
      if ($urandom_range(9) < 7) put_reg(CFG_LATERAL_PH, pick_phase());
      if ($urandom_range(9) < 7) put_reg(CFG_TICK_DIV, div_val);
      end_writes();
      n = $urandom_range(200, 40);
      repeat (n) begin
        if ($urandom_range(99) < 85) begin
          ticks_pending.push_back(1'b1);
        end else begin
          ticks_pending.push_back(1'b0);
        end
        sent_ticks++;
      end
      wait_idle();
    end

    wait_idle();
    if (mismatches == 0 && joint_goals_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
